### src/mm4_pkg.sv
package mm4_pkg;

  localparam int unsigned IDX_W  = 4;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PROD_W = 2 * VAL_W;
  // Four products of 64 bits each need two more bits of headroom.
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned STEP_W = 3;

  localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [1:0] KIND_COMPUTE     = 2'd2;

  localparam logic [STEP_W-1:0] MAC_STEPS  = 3'd4;
  localparam logic [IDX_W-1:0]  LAST_ENTRY = 4'd15;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        element_index;
    logic signed [VAL_W-1:0] element_value;
  } mm4_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        result_index;
    logic signed [VAL_W-1:0] result_value;
    logic                    last_entry;
  } mm4_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_OUT
  } mm4_state_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } mm4_mac_ctl_t;

endpackage

### src/mm4_store.sv
module mm4_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [mm4_pkg::IDX_W-1:0]        wr_addr,
  input  logic signed [mm4_pkg::VAL_W-1:0] wr_data,
  input  logic [mm4_pkg::IDX_W-1:0]        rd_addr,
  output logic signed [mm4_pkg::VAL_W-1:0] rd_data
);
  import mm4_pkg::*;

  localparam int unsigned DEPTH = 1 << IDX_W;

  logic signed [VAL_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_addr];

endmodule

### src/mm4_mac.sv
module mm4_mac #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk,
  input  mm4_pkg::mm4_mac_ctl_t            ctl,
  input  logic signed [mm4_pkg::VAL_W-1:0] op_a,
  input  logic signed [mm4_pkg::VAL_W-1:0] op_b,
  output logic signed [mm4_pkg::VAL_W-1:0] sat_value
);
  import mm4_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-VAL_W:0]     upper;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // The arithmetic shift floors the exact sum; the result fits only when
  // every bit above the 32-bit sign position matches the sign.
  assign shifted = acc_r >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:VAL_W-1];

  always_comb begin
    if ((upper == '0) || (upper == '1)) begin
      sat_value = shifted[VAL_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_value = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

endmodule

### src/mm4_seq.sv
module mm4_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      out_free,
  output mm4_pkg::mm4_mac_ctl_t     mac_ctl,
  output logic [mm4_pkg::IDX_W-1:0] second_addr,
  output logic [mm4_pkg::IDX_W-1:0] first_addr,
  output logic [mm4_pkg::IDX_W-1:0] entry,
  output logic                      load_out,
  output logic                      busy
);
  import mm4_pkg::*;

  mm4_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]  entry_r, entry_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      entry_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      entry_r <= entry_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    entry_nxt = entry_r;
    mac_ctl   = '0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MAC;
          step_nxt  = '0;
          entry_nxt = '0;
        end
      end
      ST_MAC: begin
        // The product of step k is added in the following step, so the last step
        // only drains the product register into the accumulator.
        mac_ctl.clear  = (step_r == '0);
        mac_ctl.acc_en = (step_r != '0);
        mac_ctl.mul_en = (step_r != MAC_STEPS);
        if (step_r == MAC_STEPS) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          step_nxt = '0;
          if (entry_r == LAST_ENTRY) begin
            state_nxt = ST_IDLE;
          end else begin
            entry_nxt = entry_r + 1'b1;
            state_nxt = ST_MAC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign second_addr = {entry_r[3:2], step_r[1:0]};
  assign first_addr  = {step_r[1:0], entry_r[1:0]};
  assign entry       = entry_r;
  assign busy        = (state_r != ST_IDLE);

endmodule

### src/matrix_multiply_4x4.sv
// Loads of either matrix produce no result.
// A compute transfer keeps the input stalled until the last of its sixteen results is
// loaded: every product entry takes four multiply steps on the one shared 32x32
// multiplier, an accumulate drain step and an output load step that waits on out_stall.
// Synchronous active-low reset clears both matrices to zero and idles the sequencer.
module matrix_multiply_4x4 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mm4_pkg::mm4_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mm4_pkg::mm4_out_t out_data
);
  import mm4_pkg::*;

  logic                    in_xfer;
  logic                    start;
  logic                    wr_first;
  logic                    wr_second;
  logic                    out_free;
  logic                    load_out;
  logic                    busy;
  mm4_mac_ctl_t            mac_ctl;
  logic [IDX_W-1:0]        second_addr;
  logic [IDX_W-1:0]        first_addr;
  logic [IDX_W-1:0]        entry;
  logic signed [VAL_W-1:0] first_rd;
  logic signed [VAL_W-1:0] second_rd;
  logic signed [VAL_W-1:0] sat_value;
  logic                    out_valid_r;
  mm4_out_t                out_data_r;

  assign in_xfer   = in_valid && !in_stall;
  assign start     = in_xfer && (in_data.kind == KIND_COMPUTE);
  assign wr_first  = in_xfer && (in_data.kind == KIND_LOAD_FIRST);
  assign wr_second = in_xfer && (in_data.kind == KIND_LOAD_SECOND);
  assign in_stall  = busy;

  mm4_store u_first (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_first),
    .wr_addr (in_data.element_index),
    .wr_data (in_data.element_value),
    .rd_addr (first_addr),
    .rd_data (first_rd)
  );

  mm4_store u_second (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_second),
    .wr_addr (in_data.element_index),
    .wr_data (in_data.element_value),
    .rd_addr (second_addr),
    .rd_data (second_rd)
  );

  mm4_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .out_free    (out_free),
    .mac_ctl     (mac_ctl),
    .second_addr (second_addr),
    .first_addr  (first_addr),
    .entry       (entry),
    .load_out    (load_out),
    .busy        (busy)
  );

  mm4_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .ctl       (mac_ctl),
    .op_a      (second_rd),
    .op_b      (first_rd),
    .sat_value (sat_value)
  );

  // The output register frees up in the same cycle its transfer completes.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.result_index <= entry;
      out_data_r.result_value <= sat_value;
      out_data_r.last_entry   <= (entry == LAST_ENTRY);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/mm4_check.sv
module mm4_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input mm4_pkg::mm4_out_t out_data
);
  import mm4_pkg::*;

  // No result may be offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_entry == (out_data.result_index == LAST_ENTRY)))
    else $error("last flag does not match entry index");

  // While a run is still in flight the input side must stay stalled.
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_entry |-> in_stall)
    else $error("input accepted in the middle of a product run");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_entry
    |=> !out_valid || (out_data.result_index == $past(out_data.result_index) + 4'd1))
    else $error("product entries out of order");

endmodule

bind matrix_multiply_4x4 mm4_check u_mm4_check (.*);
